// ===== design/srpc_pkg.sv =====
`default_nettype none

package srpc_pkg;

	// Path length counter width and its saturation point
	localparam int unsigned LEN_W = 13;
	typedef logic [LEN_W-1:0] len_t;
	localparam len_t LEN_MAX = len_t'(8191);

	// Bytes with a special meaning in a path
	localparam logic [7:0] CHAR_SLASH     = 8'h2F;
	localparam logic [7:0] CHAR_DOT       = 8'h2E;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_NUL       = 8'h00;

	// Component length saturates at this value
	localparam logic [1:0] COMP_LEN_SAT = 2'd3;

	// Per-path scan state
	typedef struct packed {
		len_t       length_count;
		logic [1:0] component_length;
		logic       component_all_dots;
		logic       reject_seen;
	} path_state_t;

	localparam path_state_t PATH_CLEAR = '{
		length_count:       '0,
		component_length:   2'd0,
		component_all_dots: 1'b1,
		reject_seen:        1'b0
	};

endpackage

`default_nettype wire

// ===== design/srpc_step.sv =====
`default_nettype none

// One scan step: fold a byte into the path state and form the verdict.
module srpc_step (
	input  wire srpc_pkg::path_state_t cur,
	input  wire                        char_valid,
	input  wire [7:0]                  char_byte,
	input  wire                        path_end,
	input  wire srpc_pkg::len_t        max_length,
	output srpc_pkg::path_state_t      nxt,
	output logic                       path_safe
);

	srpc_pkg::path_state_t upd;
	srpc_pkg::len_t        len_inc;
	logic                  cur_comp_bad;
	logic                  upd_comp_bad;

	assign len_inc = cur.length_count + srpc_pkg::len_t'(1);

	// Empty, "." or ".." component
	assign cur_comp_bad = (cur.component_length == 2'd0) ||
		(cur.component_all_dots && (cur.component_length != srpc_pkg::COMP_LEN_SAT));

	// Fold in the byte
	always_comb begin
		upd = cur;
		if (char_valid) begin
			if (cur.length_count == srpc_pkg::LEN_MAX) begin
				upd.reject_seen = 1'b1;
			end else begin
				upd.length_count = len_inc;
				if (len_inc > max_length) begin
					upd.reject_seen = 1'b1;
				end
			end
			if (char_byte == srpc_pkg::CHAR_SLASH) begin
				if (cur_comp_bad) begin
					upd.reject_seen = 1'b1;
				end
				upd.component_length   = 2'd0;
				upd.component_all_dots = 1'b1;
			end else begin
				if ((char_byte == srpc_pkg::CHAR_BACKSLASH) ||
				    (char_byte == srpc_pkg::CHAR_NUL)) begin
					upd.reject_seen = 1'b1;
				end
				if (cur.component_length != srpc_pkg::COMP_LEN_SAT) begin
					upd.component_length = cur.component_length + 2'd1;
				end
				if (char_byte != srpc_pkg::CHAR_DOT) begin
					upd.component_all_dots = 1'b0;
				end
			end
		end
	end

	assign upd_comp_bad = (upd.component_length == 2'd0) ||
		(upd.component_all_dots && (upd.component_length != srpc_pkg::COMP_LEN_SAT));

	// Verdict on the updated state; clear the path after its end
	assign path_safe = !(upd.reject_seen || (upd.length_count == '0) || upd_comp_bad);
	assign nxt       = path_end ? srpc_pkg::PATH_CLEAR : upd;

endmodule

`default_nettype wire

// ===== design/safe_relative_path_checker_unit.sv =====
`default_nettype none

// Safe relative path checker.
// Input channel (in_valid / in_stall): one transaction per path byte, with
// char_valid marking a real byte and path_end marking the last transaction
// of a path. A transaction may carry both a byte and the end.
// Output channel (out_valid / out_stall): one transaction per path end,
// path_safe = 1 when the path passed every check.
// Verdict flow: an accepted end transaction passes the input register, then
// the result register, which shows its verdict.
// Throughput: one transaction per cycle while in_stall is low; the scan state
// update is a single pass of logic between the input and result registers.
// Stall: a waiting verdict holds in the result register; the input side
// keeps accepting until an end transaction reaches the input register while
// the result register is still full and stalled, then in_stall rises.
// Reset: clears the scan state and both valid flags, and sets max_length to
// MAX_PATH_LEN (saturated to 8191). cfg_wr_en writes max_length.
module safe_relative_path_checker_unit #(
	parameter int unsigned MAX_PATH_LEN = 4096
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire srpc_pkg::len_t cfg_wr_data,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 char_valid,
	input  wire [7:0]           char_byte,
	input  wire                 path_end,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic                path_safe
);

	localparam int unsigned RST_LEN = (MAX_PATH_LEN > 8191) ? 8191 : MAX_PATH_LEN;
	localparam srpc_pkg::len_t RST_MAX_LEN = srpc_pkg::len_t'(RST_LEN);

	srpc_pkg::len_t        max_length_q;
	srpc_pkg::path_state_t state_q;
	srpc_pkg::path_state_t state_nxt;
	logic                  valid_s1;
	logic                  char_valid_s1;
	logic [7:0]            char_byte_s1;
	logic                  path_end_s1;
	logic                  verdict;
	logic                  out_valid_q;
	logic                  path_safe_q;
	logic                  adv_s1;
	logic                  load_s1;

	// Stage 1 moves on unless it holds an end and the result slot is blocked
	assign adv_s1   = !(valid_s1 && path_end_s1 && out_valid_q && out_stall);
	assign in_stall = !adv_s1;
	assign load_s1  = in_valid && adv_s1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= RST_MAX_LEN;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			char_valid_s1 <= char_valid;
			char_byte_s1  <= char_byte;
			path_end_s1   <= path_end;
		end
	end

	srpc_step u_step (
		.cur        (state_q),
		.char_valid (char_valid_s1),
		.char_byte  (char_byte_s1),
		.path_end   (path_end_s1),
		.max_length (max_length_q),
		.nxt        (state_nxt),
		.path_safe  (verdict)
	);

	// Scan state: advance on each transaction leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srpc_pkg::PATH_CLEAR;
		end else if (valid_s1 && adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on path end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && path_end_s1 && adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && path_end_s1 && adv_s1) begin
			path_safe_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign path_safe = path_safe_q;

endmodule

`default_nettype wire

// ===== design/srpc_checker.sv =====
`default_nettype none

module srpc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire       char_valid,
	input wire [7:0] char_byte,
	input wire       path_end,
	input wire       out_valid,
	input wire       out_stall,
	input wire       path_safe
);

	// A stalled verdict holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(path_safe))
		else $error("verdict changed while stalled");

	// Input backs up only behind a stalled verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked verdict");

	// A verdict appears only after an accepted end transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && path_end, 2))
		else $error("verdict without an end transaction");

	// Ending on a slash, backslash or NUL always rejects the path
	a_bad_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && path_end && char_valid &&
		 ((char_byte == srpc_pkg::CHAR_SLASH) ||
		  (char_byte == srpc_pkg::CHAR_BACKSLASH) ||
		  (char_byte == srpc_pkg::CHAR_NUL)))
		##1 (!out_valid || !out_stall) |=> out_valid && !path_safe)
		else $error("bad final byte not rejected");

endmodule

bind safe_relative_path_checker_unit srpc_checker u_srpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.char_valid (char_valid),
	.char_byte  (char_byte),
	.path_end   (path_end),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.path_safe  (path_safe)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RESET_MAX_LEN = 4096;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned ITEMS_PER_PHASE = 150;
	localparam int unsigned REPORT_LIMIT = 10;

	// One input transaction: optional path byte, optional path end
	typedef struct packed {
		logic       has_byte;
		logic [7:0] byte_val;
		logic       last;
	} path_item_t;

	// Path scan predictor and queue of expected verdicts
	class path_verdict_board;
		srpc_pkg::len_t limit_len;
		srpc_pkg::len_t seen_len;
		logic [1:0] comp_len;
		bit         comp_dots;
		bit         rejected;
		bit         expected_verdicts[$];
		int unsigned mismatches;

		function new(srpc_pkg::len_t reset_len);
			limit_len = reset_len;
			mismatches = 0;
			clear_path();
		endfunction

		function void clear_path();
			seen_len = '0;
			comp_len = 2'd0;
			comp_dots = 1'b1;
			rejected = 1'b0;
		endfunction

		// Empty, "." or ".." component
		function bit comp_is_bad();
			return (comp_len == 2'd0) || (comp_dots && comp_len <= 2'd2);
		endfunction

		// Advance the scan state by one accepted transaction
		function void note_transaction(path_item_t it);
			if (it.has_byte) begin
				if (seen_len >= srpc_pkg::LEN_MAX) begin
					rejected = 1'b1;
				end else begin
					seen_len = seen_len + 1'b1;
					if (seen_len > limit_len) rejected = 1'b1;
				end
				if (it.byte_val == srpc_pkg::CHAR_SLASH) begin
					if (comp_is_bad()) rejected = 1'b1;
					comp_len = 2'd0;
					comp_dots = 1'b1;
				end else begin
					if (it.byte_val == srpc_pkg::CHAR_BACKSLASH ||
					    it.byte_val == srpc_pkg::CHAR_NUL)
						rejected = 1'b1;
					if (comp_len < srpc_pkg::COMP_LEN_SAT) comp_len = comp_len + 1'b1;
					if (it.byte_val != srpc_pkg::CHAR_DOT) comp_dots = 1'b0;
				end
			end
			if (it.last) begin
				expected_verdicts.insert(expected_verdicts.size(),
					!(rejected || seen_len == '0 || comp_is_bad()));
				clear_path();
			end
		endfunction

		// Compare one delivered verdict with the oldest expected one
		function void check_verdict(bit got);
			bit want;
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("[%0t] unexpected verdict: path_safe=%0b", $realtime, got);
				return;
			end
			want = expected_verdicts.pop_front();
			if (want != got) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("[%0t] path_safe mismatch: expected %0b, got %0b",
						$realtime, want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           cfg_wr_en;
	srpc_pkg::len_t cfg_wr_data;
	logic           in_valid;
	logic           in_stall;
	logic           char_valid;
	logic [7:0]     char_byte;
	logic           path_end;
	logic           out_valid;
	logic           out_stall;
	logic           path_safe;

	path_verdict_board board;
	path_item_t stim_q[$];
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned hold_left;
	int unsigned sent_real;
	int unsigned cycle_count;

	safe_relative_path_checker_unit #(
		.MAX_PATH_LEN(RESET_MAX_LEN)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_valid (char_valid),
		.char_byte  (char_byte),
		.path_end   (path_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.path_safe  (path_safe)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Receiver: check delivered verdicts, then stall at random or hold off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) board.check_verdict(path_safe);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic path_item_t mk_item(bit has_byte, logic [7:0] b, bit last);
		path_item_t it;
		it.has_byte = has_byte;
		it.byte_val = b;
		it.last = last;
		return it;
	endfunction

	function automatic void add_byte(logic [7:0] b);
		stim_q.insert(stim_q.size(), mk_item(1'b1, b, 1'b0));
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	// Close the path: fold the end into the last byte or send an end-only transaction
	function automatic void add_end(bit merge);
		int unsigned n;
		n = stim_q.size();
		if (merge && n > 0 && stim_q[n-1].has_byte && !stim_q[n-1].last)
			stim_q[n-1].last = 1'b1;
		else
			stim_q.insert(stim_q.size(), mk_item(1'b0, 8'($urandom), 1'b1));
	endfunction

	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4) return 8'($urandom);
		if (r < 6) return srpc_pkg::CHAR_BACKSLASH;
		if (r < 7) return srpc_pkg::CHAR_NUL;
		if (r < 19) return srpc_pkg::CHAR_DOT;
		if (r < 22) return "-";
		return 8'("a") + 8'($urandom_range(25));
	endfunction

	// Mostly well-formed paths with random content, some broken ones and noise
	function automatic void add_random_path(int unsigned max_len);
		int unsigned start;
		int unsigned goal;
		int unsigned n;
		int unsigned r;
		bit first;
		start = stim_q.size();
		if ($urandom_range(99) < 10) begin
			n = $urandom_range(0, 8);
			repeat (n) stim_q.insert(stim_q.size(),
				mk_item(1'($urandom), 8'($urandom), 1'b0));
			stim_q.insert(stim_q.size(), mk_item(1'($urandom), 8'($urandom), 1'b1));
			return;
		end
		goal = (max_len < 20) ? $urandom_range(1, max_len + 3) : $urandom_range(1, 20);
		first = 1'b1;
		if ($urandom_range(99) < 4) add_byte(srpc_pkg::CHAR_SLASH);
		while (stim_q.size() - start < goal) begin
			if (!first) add_byte(srpc_pkg::CHAR_SLASH);
			first = 1'b0;
			r = $urandom_range(99);
			if (r < 8) begin
				add_byte(srpc_pkg::CHAR_DOT);
			end else if (r < 14) begin
				add_text("..");
			end else if (r < 18) begin
				add_text("...");
			end else if (r >= 22) begin
				repeat ($urandom_range(1, 4)) add_byte(pick_char());
			end
		end
		if ($urandom_range(99) < 4) add_byte(srpc_pkg::CHAR_SLASH);
		if ($urandom_range(99) < 5 && stim_q.size() > start)
			stim_q.insert($urandom_range(start, stim_q.size() - 1),
				mk_item(1'b0, 8'($urandom), 1'b0));
		add_end($urandom_range(1));
	endfunction

	// Offer one transaction, with optional idle cycles first, and wait for acceptance
	task automatic push_item(path_item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_valid <= it.has_byte;
		char_byte <= it.byte_val;
		path_end <= it.last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_transaction(it);
		if (it.has_byte || it.last) sent_real++;
	endtask

	task automatic play_stim();
		while (stim_q.size() > 0) push_item(stim_q.pop_front());
	endtask

	// Drop valid, wait for every verdict, then let trailing no-op transactions leave
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(srpc_pkg::len_t v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.limit_len = v;
	endtask

	task automatic set_idling(int unsigned mode);
		case (mode)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 51;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 51;
			end
			default: begin
				send_idle_pct = 10;
				stall_pct = 10;
			end
		endcase
	endtask

	// Main sequence
	initial begin
		int unsigned phase_max[8];
		int unsigned goal;
		phase_max = '{1, 0, 16, 8191, 3, 4096, 7, 2};
		board = new(srpc_pkg::len_t'(RESET_MAX_LEN));
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		char_valid = 1'b0;
		char_byte = 8'h00;
		path_end = 1'b0;
		hold_left = 0;
		sent_real = 0;
		set_idling(0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty path, byte and end together, slashes, dots, bad bytes
		add_end(1'b0);
		add_text("a");
		add_end(1'b1);
		add_text("/a");
		add_end(1'b1);
		add_text("b/");
		add_end(1'b1);
		add_text("c//d");
		add_end(1'b1);
		add_text(".");
		add_end(1'b1);
		add_text("..");
		add_end(1'b1);
		add_text("...");
		add_end(1'b1);
		add_text("x");
		add_byte(srpc_pkg::CHAR_BACKSLASH);
		add_end(1'b1);
		add_text("y");
		add_byte(srpc_pkg::CHAR_NUL);
		add_end(1'b1);
		add_text("z");
		stim_q.insert(stim_q.size(), mk_item(1'b0, 8'hA5, 1'b0));
		add_end(1'b0);
		add_byte(8'hFF);
		add_byte(8'h80);
		add_end(1'b1);
		play_stim();

		// Hold off the receiver while paths keep coming, so the input backs up
		hold_left = 300;
		repeat (40) begin
			add_random_path(RESET_MAX_LEN);
			play_stim();
		end

		// Register phases, each with one of the four idling modes
		for (int p = 0; p < 8; p++) begin
			write_max_len(srpc_pkg::len_t'(phase_max[p]));
			set_idling(p % 4);
			goal = sent_real + ITEMS_PER_PHASE;
			while (sent_real < goal) begin
				add_random_path(phase_max[p]);
				play_stim();
			end
		end

		drain();
		if (board.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
